### hdl/cpt_pkg.sv
// Shared types for the closest-point-on-triangle pipeline.
// No dependencies.
`timescale 1ns / 1ps

package cpt_pkg;

  // How the t parameter is formed once s is known.
  typedef enum logic {
    T_RATIO,
    T_COMPLEMENT
  } tmode_e;

  // Control that rides alongside the dividers.
  typedef struct packed {
    tmode_e tmode;
    logic   deg;
  } side_t;

endpackage

### hdl/cpt_dly.sv
// Enabled delay line for payload that rides alongside the datapath.
// No dependencies.
`timescale 1ns / 1ps

module cpt_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

### hdl/cpt_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
// No dependencies.
`timescale 1ns / 1ps

module cpt_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int LA = AW / 2;
  localparam int HA = AW - LA;
  localparam int LB = BW / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic signed [HA+HB-1:0] hh_q;
  logic signed [HA+LB:0]   hl_q;
  logic signed [LA+HB:0]   lh_q;
  logic        [LA+LB-1:0] ll_q;
  logic signed [PW-1:0]    p_q;

  // First stage: partial products, low halves taken as unsigned.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= $signed(a_i[AW-1:LA]) * $signed(b_i[BW-1:LB]);
      hl_q <= $signed(a_i[AW-1:LA]) * $signed({1'b0, b_i[LB-1:0]});
      lh_q <= $signed({1'b0, a_i[LA-1:0]}) * $signed(b_i[BW-1:LB]);
      ll_q <= a_i[LA-1:0] * b_i[LB-1:0];
    end
  end

  // Second stage: align and sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (PW'(hh_q) <<< (LA + LB)) + (PW'(hl_q) <<< LA) + (PW'(lh_q) <<< LB)
             + $signed(PW'(ll_q));
    end
  end

  assign p_o = p_q;

endmodule

### hdl/cpt_div.sv
// Pipelined restoring divider giving clamp(n/m, 0, 1) as a QB-bit fraction.
// No dependencies.
`timescale 1ns / 1ps

module cpt_div #(
  parameter int NW = 138,
  parameter int QB = 34
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [NW-1:0] den_i,
  output logic        [QB:0]   quo_o
);

  logic [NW-1:0] rem_q  [QB+1];
  logic [NW-1:0] den_q  [QB+1];
  logic [QB-1:0] quo_q  [QB+1];
  logic          zero_q [QB+1];
  logic          one_q  [QB+1];

  // Entry stage: settle the clamped cases.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= num_i[NW-1] || (num_i == '0);
      one_q[0]  <= !(num_i < den_i);
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
    end
  end

  // One quotient bit per stage.
  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [NW-1:0] shl;
    logic          ge;
    assign shl = {rem_q[i-1][NW-2:0], 1'b0};
    assign ge  = (shl >= den_q[i-1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? shl - den_q[i-1] : shl;
        den_q[i]  <= den_q[i-1];
        quo_q[i]  <= {quo_q[i-1][QB-2:0], ge};
        zero_q[i] <= zero_q[i-1];
        one_q[i]  <= one_q[i-1];
      end
    end
  end

  always_comb begin
    if (zero_q[QB]) begin
      quo_o = '0;
    end else if (one_q[QB]) begin
      quo_o = (QB+1)'(1) << QB;
    end else begin
      quo_o = {1'b0, quo_q[QB]};
    end
  end

endmodule

### hdl/closest_point_on_triangle.sv
// Closest point on a triangle to a query point, fully pipelined.
// Depends on cpt_pkg, cpt_dly, cpt_mul and cpt_div.
`timescale 1ns / 1ps

// Each transfer on the input channel carries the three vertices of a triangle and a
// query point as signed fixed-point coordinates; each transfer on the output channel
// carries the point of the filled triangle nearest to the query, saturated to the
// coordinate range, plus a flag that marks a degenerate triangle (zero area), in
// which case the result is vertex a. Arithmetic is exact: edge dot products, the
// barycentric numerators and the area are kept at full width, and the parameters
// s and t come from clamped ratios with COORD_WIDTH+2 fraction bits, rounded half up
// when applied. A new query is taken every cycle unless the output stalls. The longest
// part is the pair of restoring dividers, which produce one quotient bit per stage over
// COORD_WIDTH+2 stages behind one entry stage. The whole pipeline advances together:
// it holds while a finished result waits on the output, and the input is ready
// whenever the output register is empty or being taken.

module closest_point_on_triangle
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] vert_c_z_i,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] query_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] near_x_o,
  output logic signed [COORD_WIDTH-1:0] near_y_o,
  output logic signed [COORD_WIDTH-1:0] near_z_o,
  output logic                          degenerate_o
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;          // edge and offset vectors
  localparam int PRW = 2 * DW;         // one coordinate product
  localparam int PW  = 2 * W + 4;      // dot products
  localparam int MW  = 2 * PW;         // dot times dot
  localparam int AW  = MW + 1;         // area and barycentric numerators
  localparam int NW  = AW + 1;         // divider operands
  localparam int PF  = W + 2;          // parameter fraction bits
  localparam int PSW = PF + 1;         // parameter width, holds exactly one
  localparam int QL  = PF + 1;         // divider pipeline stages
  localparam int ST  = 8 + QL;         // stage that registers s and t
  localparam int NS  = ST + 3;         // total pipeline depth
  localparam int FMW = DW + PSW + 1;   // final product width
  localparam int SW  = FMW + 1;        // final sum width
  localparam int TW  = SW - PF + 1;    // shifted sum plus vertex a

  localparam int DUU = 0;
  localparam int DUV = 1;
  localparam int DVV = 2;
  localparam int DUW = 3;
  localparam int DVW = 4;

  localparam logic [PSW-1:0] ONE = PSW'(1) << PF;

  logic          en;
  logic [NS-1:0] vld_q;

  // Advance everything unless the output holds an untaken result.
  assign en          = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: edge vectors u = b - a, v = c - a and offset w = a - q.
  logic signed [W-1:0]  pa_c [3];
  logic signed [W-1:0]  pb_c [3];
  logic signed [W-1:0]  pc_c [3];
  logic signed [W-1:0]  pq_c [3];
  logic signed [DW-1:0] u_q  [3];
  logic signed [DW-1:0] v_q  [3];
  logic signed [DW-1:0] w_q  [3];
  logic signed [W-1:0]  pa_q [3];

  assign pa_c = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign pb_c = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
  assign pc_c = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};
  assign pq_c = '{query_x_i, query_y_i, query_z_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k]  <= DW'(pb_c[k]) - DW'(pa_c[k]);
        v_q[k]  <= DW'(pc_c[k]) - DW'(pa_c[k]);
        w_q[k]  <= DW'(pa_c[k]) - DW'(pq_c[k]);
        pa_q[k] <= pa_c[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the fifteen coordinate products. Stage 3: sum into dot products.
  logic signed [PRW-1:0] pr_q  [5][3];
  logic signed [PW-1:0]  dot_q [5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[DUU][k] <= PRW'(u_q[k]) * PRW'(u_q[k]);
        pr_q[DUV][k] <= PRW'(u_q[k]) * PRW'(v_q[k]);
        pr_q[DVV][k] <= PRW'(v_q[k]) * PRW'(v_q[k]);
        pr_q[DUW][k] <= PRW'(u_q[k]) * PRW'(w_q[k]);
        pr_q[DVW][k] <= PRW'(v_q[k]) * PRW'(w_q[k]);
      end
      for (int d = 0; d < 5; d++) begin
        dot_q[d] <= PW'(pr_q[d][0]) + PW'(pr_q[d][1]) + PW'(pr_q[d][2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4-5: products of dot products for area and the two numerators.
  logic signed [PW-1:0] ma [6];
  logic signed [PW-1:0] mb [6];
  logic signed [MW-1:0] mp [6];

  assign ma = '{dot_q[DUU], dot_q[DUV], dot_q[DUV], dot_q[DVV], dot_q[DUV], dot_q[DUU]};
  assign mb = '{dot_q[DVV], dot_q[DUV], dot_q[DVW], dot_q[DUW], dot_q[DUW], dot_q[DVW]};

  for (genvar j = 0; j < 6; j++) begin : g_dmul
    cpt_mul #(
      .AW(PW),
      .BW(PW)
    ) u_mul (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (ma[j]),
      .b_i  (mb[j]),
      .p_o  (mp[j])
    );
  end

  // Hold the dot products alongside the multipliers.
  logic [5*PW-1:0]      dot_pk;
  logic [5*PW-1:0]      dotd_pk;
  logic signed [PW-1:0] dd [5];

  assign dot_pk = {dot_q[4], dot_q[3], dot_q[2], dot_q[1], dot_q[0]};

  cpt_dly #(
    .WIDTH(5 * PW),
    .DEPTH(2)
  ) u_dot_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (dot_pk),
    .q_o  (dotd_pk)
  );

  for (genvar d = 0; d < 5; d++) begin : g_dunpk
    assign dd[d] = $signed(dotd_pk[d*PW +: PW]);
  end

  // ---------------------------------------------------------------------------
  // Stage 6: area, numerators, and the edge-region terms.
  logic signed [AW-1:0]   area_q, sn_q, tn_q;
  logic signed [PW+1:0]   den_q, far_q;
  logic signed [PW:0]     nuw_q, nvw_q;
  logic signed [PW-1:0]   uu_q, vv_q;
  logic                   cmpa_q, cmpb_q, uwneg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q  <= AW'(mp[0]) - AW'(mp[1]);
      sn_q    <= AW'(mp[2]) - AW'(mp[3]);
      tn_q    <= AW'(mp[4]) - AW'(mp[5]);
      den_q   <= (PW+2)'(dd[DUU]) + (PW+2)'(dd[DVV]) - (PW+2)'(dd[DUV])
                 - (PW+2)'(dd[DUV]);
      far_q   <= (PW+2)'(dd[DVV]) + (PW+2)'(dd[DVW]) - (PW+2)'(dd[DUV])
                 - (PW+2)'(dd[DUW]);
      cmpa_q  <= ((PW+1)'(dd[DUV]) + (PW+1)'(dd[DUW]))
                 < ((PW+1)'(dd[DVV]) + (PW+1)'(dd[DVW]));
      cmpb_q  <= ((PW+1)'(dd[DUV]) + (PW+1)'(dd[DVW]))
                 < ((PW+1)'(dd[DUU]) + (PW+1)'(dd[DUW]));
      nuw_q   <= -(PW+1)'(dd[DUW]);
      nvw_q   <= -(PW+1)'(dd[DVW]);
      uu_q    <= dd[DUU];
      vv_q    <= dd[DVV];
      uwneg_q <= dd[DUW][PW-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: Voronoi region select. A zero numerator forces that ratio to zero.
  logic signed [NW-1:0] s_num_d, s_den_d, t_num_d, t_den_d;
  logic signed [NW-1:0] s_num_q, s_den_q, t_num_q, t_den_q;
  side_t                side_d, side_q;
  logic                 in_tri;
  logic                 sneg, tneg;

  assign in_tri = (NW'(sn_q) + NW'(tn_q)) < NW'(area_q);
  assign sneg   = sn_q[AW-1];
  assign tneg   = tn_q[AW-1];

  always_comb begin
    // Default: edge bc, s from the far ratio and t = 1 - s.
    s_num_d      = NW'(far_q);
    s_den_d      = NW'(den_q);
    t_num_d      = '0;
    t_den_d      = NW'(den_q);
    side_d.tmode = T_COMPLEMENT;
    side_d.deg   = (area_q == '0);
    if (in_tri) begin
      side_d.tmode = T_RATIO;
      if (sneg && !(tneg && uwneg_q)) begin
        // Edge ca.
        s_num_d = '0;
        t_num_d = NW'(nvw_q);
        t_den_d = NW'(vv_q);
      end else if (sneg || tneg) begin
        // Edge ab.
        s_num_d = NW'(nuw_q);
        s_den_d = NW'(uu_q);
      end else begin
        // Interior.
        s_num_d = NW'(sn_q);
        s_den_d = NW'(area_q);
        t_num_d = NW'(tn_q);
        t_den_d = NW'(area_q);
      end
    end else if (sneg && !cmpa_q) begin
      side_d.tmode = T_RATIO;
      s_num_d      = '0;
      t_num_d      = NW'(nvw_q);
      t_den_d      = NW'(vv_q);
    end else if (!sneg && tneg && !cmpb_q) begin
      side_d.tmode = T_RATIO;
      s_num_d      = NW'(nuw_q);
      s_den_d      = NW'(uu_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_num_q <= s_num_d;
      s_den_q <= s_den_d;
      t_num_q <= t_num_d;
      t_den_q <= t_den_d;
      side_q  <= side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers for s and t, with the control riding alongside.
  logic [PSW-1:0] qs, qt;
  side_t          side_dv;

  cpt_div #(
    .NW(NW),
    .QB(PF)
  ) u_div_s (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(s_num_q),
    .den_i(s_den_q),
    .quo_o(qs)
  );

  cpt_div #(
    .NW(NW),
    .QB(PF)
  ) u_div_t (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(t_num_q),
    .den_i(t_den_q),
    .quo_o(qt)
  );

  cpt_dly #(
    .WIDTH($bits(side_t)),
    .DEPTH(QL)
  ) u_side_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (side_q),
    .q_o  (side_dv)
  );

  // Register s and t; a degenerate triangle drops both to zero so the
  // result falls back to vertex a.
  logic [PSW-1:0] ps_q, pt_q;
  logic           deg_st_q;
  tmode_e         tmode_st_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_st_q   <= side_dv.deg;
      tmode_st_q <= side_dv.tmode;
      if (side_dv.deg) begin
        ps_q <= '0;
        pt_q <= '0;
      end else begin
        ps_q <= qs;
        pt_q <= (side_dv.tmode == T_COMPLEMENT) ? ONE - qs : qt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Carry u, v and vertex a forward to the final multiply and sum.
  logic [6*DW-1:0]      uv_pk, uvd_pk;
  logic [3*W-1:0]       pa_pk, pad_pk;
  logic signed [DW-1:0] ud [3];
  logic signed [DW-1:0] vd [3];
  logic signed [W-1:0]  pad [3];
  logic                 deg_f;

  assign uv_pk = {v_q[2], v_q[1], v_q[0], u_q[2], u_q[1], u_q[0]};
  assign pa_pk = {pa_q[2], pa_q[1], pa_q[0]};

  cpt_dly #(
    .WIDTH(6 * DW),
    .DEPTH(ST - 1)
  ) u_uv_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (uv_pk),
    .q_o  (uvd_pk)
  );

  cpt_dly #(
    .WIDTH(3 * W),
    .DEPTH(ST + 1)
  ) u_pa_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (pa_pk),
    .q_o  (pad_pk)
  );

  cpt_dly #(
    .WIDTH(1),
    .DEPTH(2)
  ) u_deg_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (deg_st_q),
    .q_o  (deg_f)
  );

  // ---------------------------------------------------------------------------
  // Final multiply u*s and v*t, then round, shift, add vertex a and saturate.
  logic signed [PSW:0]      ps_s, pt_s;
  logic signed [FMW-1:0]    fpu [3];
  logic signed [FMW-1:0]    fpv [3];
  logic signed [W-1:0]      near_q [3];
  logic                     deg_q;

  assign ps_s = $signed({1'b0, ps_q});
  assign pt_s = $signed({1'b0, pt_q});

  for (genvar k = 0; k < 3; k++) begin : g_fin
    logic signed [SW-1:0] sum;
    logic signed [TW-1:0] tot;
    logic signed [W-1:0]  sat;

    assign ud[k]  = $signed(uvd_pk[k*DW +: DW]);
    assign vd[k]  = $signed(uvd_pk[(k+3)*DW +: DW]);
    assign pad[k] = $signed(pad_pk[k*W +: W]);

    cpt_mul #(
      .AW(DW),
      .BW(PSW + 1)
    ) u_mul_u (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (ud[k]),
      .b_i  (ps_s),
      .p_o  (fpu[k])
    );

    cpt_mul #(
      .AW(DW),
      .BW(PSW + 1)
    ) u_mul_v (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (vd[k]),
      .b_i  (pt_s),
      .p_o  (fpv[k])
    );

    assign sum = SW'(fpu[k]) + SW'(fpv[k]) + (SW'(1) <<< (PF - 1));
    assign tot = TW'($signed(sum[SW-1:PF])) + TW'(pad[k]);

    always_comb begin
      if (tot > $signed({{(TW-W+1){1'b0}}, {(W-1){1'b1}}})) begin
        sat = {1'b0, {(W-1){1'b1}}};
      end else if (tot < $signed({{(TW-W+1){1'b1}}, {(W-1){1'b0}}})) begin
        sat = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat = tot[W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        near_q[k] <= sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q <= deg_f;
    end
  end

  assign near_x_o     = near_q[0];
  assign near_y_o     = near_q[1];
  assign near_z_o     = near_q[2];
  assign degenerate_o = deg_q;

`ifndef ASSERT_OFF
  // On the edge bc, s and t must add to exactly one.
  a_complement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST-1] && !deg_st_q && (tmode_st_q == T_COMPLEMENT)
    |-> ((PSW+1)'(ps_q) + (PSW+1)'(pt_q)) == (PSW+1)'(ONE))
    else $error("s and t do not sum to one on edge bc");

  // Parameters never leave [0, 1].
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST-1] |-> (ps_q <= ONE) && (pt_q <= ONE))
    else $error("barycentric parameter above one");

  // A stall freezes every valid bit in the pipeline.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");
`endif

endmodule

### verif/tb_closest_point_on_triangle.sv
// Self-checking testbench for closest_point_on_triangle.
// Depends on cpt_pkg and the block's RTL.
// Checks every result against a bit-exact predictor of the geometry.
`timescale 1ns / 1ps

module tb_closest_point_on_triangle;
  import cpt_pkg::*;

  localparam int CW = 32;
  localparam int PFRAC = CW + 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = CW + 30;
  localparam int RANDOM_QUERIES = 800;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [255:0] wint_t;

  // Twelve coordinates: a, b, c, then the query point, each x, y, z.
  typedef struct {
    crd_t c[12];
  } query_t;

  typedef struct {
    crd_t near[3];
    logic deg;
  } near_t;

  // Holds the expected nearest points in transfer order and checks results.
  class nearest_board;
    near_t pending[$];
    int    errors;

    function wint_t dot3(wint_t a[3], wint_t b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Clamped ratio n/m with PFRAC fraction bits.
    function wint_t clamp_ratio(wint_t n, wint_t m);
      if (n <= 0) return 0;
      if (n >= m) return wint_t'(1) <<< PFRAC;
      return (n <<< PFRAC) / m;
    endfunction

    function near_t nearest(query_t q);
      near_t r;
      wint_t u[3], v[3], w[3];
      wint_t uu, uv, vv, uw, vw, area, sn, tn, den, far, ps, pt, acc, one;
      one = wint_t'(1) <<< PFRAC;
      for (int k = 0; k < 3; k++) begin
        u[k] = wint_t'(q.c[3+k]) - wint_t'(q.c[k]);
        v[k] = wint_t'(q.c[6+k]) - wint_t'(q.c[k]);
        w[k] = wint_t'(q.c[k]) - wint_t'(q.c[9+k]);
      end
      uu = dot3(u, u); uv = dot3(u, v); vv = dot3(v, v);
      uw = dot3(u, w); vw = dot3(v, w);
      area = uu * vv - uv * uv;
      sn = uv * vw - vv * uw;
      tn = uv * uw - uu * vw;
      if (area == 0) begin
        for (int k = 0; k < 3; k++) r.near[k] = q.c[k];
        r.deg = 1'b1;
        return r;
      end
      den = uu + vv - 2 * uv;
      far = vv + vw - uv - uw;
      if (sn + tn < area) begin
        if (sn < 0) begin
          if (tn < 0 && uw < 0) begin
            ps = clamp_ratio(-uw, uu); pt = 0;
          end else begin
            ps = 0; pt = clamp_ratio(-vw, vv);
          end
        end else if (tn < 0) begin
          ps = clamp_ratio(-uw, uu); pt = 0;
        end else begin
          ps = clamp_ratio(sn, area); pt = clamp_ratio(tn, area);
        end
      end else begin
        if (sn < 0) begin
          if (uv + uw < vv + vw) begin
            ps = clamp_ratio(far, den); pt = one - ps;
          end else begin
            ps = 0; pt = clamp_ratio(-vw, vv);
          end
        end else if (tn < 0) begin
          if (uv + vw < uu + uw) begin
            ps = clamp_ratio(far, den); pt = one - ps;
          end else begin
            ps = clamp_ratio(-uw, uu); pt = 0;
          end
        end else begin
          ps = clamp_ratio(far, den); pt = one - ps;
        end
      end
      // Round half up, then saturate to the coordinate range.
      for (int k = 0; k < 3; k++) begin
        acc = u[k] * ps + v[k] * pt + (wint_t'(1) <<< (PFRAC - 1));
        acc = (acc >>> PFRAC) + wint_t'(q.c[k]);
        if (acc < -(wint_t'(1) <<< (CW - 1))) r.near[k] = {1'b1, {(CW-1){1'b0}}};
        else if (acc > (wint_t'(1) <<< (CW - 1)) - 1) r.near[k] = {1'b0, {(CW-1){1'b1}}};
        else r.near[k] = acc[CW-1:0];
      end
      r.deg = 1'b0;
      return r;
    endfunction

    function void note_query(query_t q);
      pending.push_back(nearest(q));
    endfunction

    function void report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endfunction

    function void check_result(crd_t nx, crd_t ny, crd_t nz, logic deg);
      near_t e;
      if (pending.size() == 0) begin
        report("result with no query outstanding");
        return;
      end
      e = pending.pop_front();
      if (nx !== e.near[0]) report($sformatf("near_x %0d, expected %0d", nx, e.near[0]));
      if (ny !== e.near[1]) report($sformatf("near_y %0d, expected %0d", ny, e.near[1]));
      if (nz !== e.near[2]) report($sformatf("near_z %0d, expected %0d", nz, e.near[2]));
      if (deg !== e.deg) report($sformatf("degenerate %0b, expected %0b", deg, e.deg));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  crd_t drv[12] = '{default: '0};
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  crd_t near_x_o, near_y_o, near_z_o;
  logic degenerate_o;

  nearest_board board = new();
  bit   no_idle = 1'b0;
  bit   accepted_now;
  int   quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  closest_point_on_triangle #(.COORD_WIDTH(CW)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .vert_a_x_i   (drv[0]),
    .vert_a_y_i   (drv[1]),
    .vert_a_z_i   (drv[2]),
    .vert_b_x_i   (drv[3]),
    .vert_b_y_i   (drv[4]),
    .vert_b_z_i   (drv[5]),
    .vert_c_x_i   (drv[6]),
    .vert_c_y_i   (drv[7]),
    .vert_c_z_i   (drv[8]),
    .query_x_i    (drv[9]),
    .query_y_i    (drv[10]),
    .query_z_i    (drv[11]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .near_x_o     (near_x_o),
    .near_y_o     (near_y_o),
    .near_z_o     (near_z_o),
    .degenerate_o (degenerate_o)
  );

  // Present one query, hold it until the transfer, then note it.
  task automatic send_query(query_t q);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 12; i++) drv[i] <= q.c[i];
    do @(posedge clk_i); while (!in_ready_o);
    board.note_query(q);
  endtask

  function automatic crd_t small_coord();
    return crd_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  function automatic crd_t corner_coord();
    case ($urandom_range(4))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return crd_t'($urandom());
    endcase
  endfunction

  // Mostly small, well-formed triangles with the query spread around them;
  // some full-range, some extreme, and some degenerate ones.
  function automatic query_t random_query();
    query_t q;
    int kind, f;
    kind = $urandom_range(99);
    for (int i = 0; i < 12; i++) begin
      if (kind < 60) q.c[i] = small_coord();
      else if (kind < 80) q.c[i] = crd_t'($urandom());
      else q.c[i] = corner_coord();
    end
    if (kind >= 90) begin
      f = $urandom_range(4) - 2;
      for (int k = 0; k < 3; k++) begin
        if (kind < 94) q.c[3+k] = q.c[k];
        else q.c[6+k] = q.c[k] + f * (q.c[3+k] - q.c[k]);
      end
    end
    return q;
  endfunction

  function automatic query_t make_query(crd_t a[3], crd_t b[3], crd_t c[3], crd_t p[3]);
    query_t q;
    for (int k = 0; k < 3; k++) begin
      q.c[k] = a[k]; q.c[3+k] = b[k]; q.c[6+k] = c[k]; q.c[9+k] = p[k];
    end
    return q;
  endfunction

  // Sink side: randomly stall, check every result transfer.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      board.check_result(near_x_o, near_y_o, near_z_o, degenerate_o);
    out_ready_i <= no_idle || ($urandom_range(99) >= 23);
  end

  // Watchdog: count cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    accepted_now = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i);
    if (!rst_ni || accepted_now || board.pending.size() == 0 && !in_valid_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    crd_t o[3], x1[3], y1[3], mx[3], mn[3];
    crd_t one_u;
    query_t q;
    one_u = crd_t'(1 << 12);
    o = '{0, 0, 0};
    x1 = '{1 << 14, 0, 0};
    y1 = '{0, 1 << 14, 0};
    mx = '{default: {1'b0, {(CW-1){1'b1}}}};
    mn = '{default: {1'b1, {(CW-1){1'b0}}}};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: inside, each vertex region, each edge region, far side.
    send_query(make_query(o, x1, y1, '{one_u, one_u, one_u}));
    send_query(make_query(o, x1, y1, '{-one_u, -one_u, 0}));
    send_query(make_query(o, x1, y1, '{crd_t'(5 << 14), -one_u, 0}));
    send_query(make_query(o, x1, y1, '{-one_u, crd_t'(5 << 14), 0}));
    send_query(make_query(o, x1, y1, '{one_u, -one_u, one_u}));
    send_query(make_query(o, x1, y1, '{-one_u, one_u, -one_u}));
    send_query(make_query(o, x1, y1, '{crd_t'(3 << 13), crd_t'(3 << 13), 0}));
    send_query(make_query(o, x1, y1, '{crd_t'(3 << 14), crd_t'(1 << 12), 0}));
    send_query(make_query(o, x1, y1, '{crd_t'(1 << 12), crd_t'(3 << 14), 0}));
    send_query(make_query(o, x1, y1, '{crd_t'(-1 << 14), crd_t'(1 << 12), 0}));
    send_query(make_query(o, x1, y1, '{crd_t'(1 << 12), crd_t'(-1 << 14), 0}));
    // Degenerate: every vertex equal, a zero edge, collinear vertices.
    send_query(make_query(x1, x1, x1, y1));
    send_query(make_query(o, o, y1, x1));
    send_query(make_query(o, x1, '{1 << 15, 0, 0}, y1));
    // Extremes: full-range triangles and queries, saturating results.
    send_query(make_query(mn, '{mx[0], mn[1], mn[2]}, '{mn[0], mx[1], mn[2]}, mx));
    send_query(make_query(mx, '{mn[0], mx[1], mx[2]}, '{mx[0], mn[1], mx[2]}, mn));
    send_query(make_query(mx, mn, '{mx[0], mn[1], 0}, o));
    send_query(make_query(mn, mx, '{mn[0], mx[1], 0}, mx));
    send_query(make_query(o, mx, '{mx[0], 0, mn[2]}, mn));
    send_query(make_query('{-1, -1, -1}, '{0, -1, -1}, '{-1, 0, -1}, mx));

    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      no_idle = (n >= 300 && n < 420);
      // Drain the pipeline once, mid-run, before going on.
      if (n == 500) begin
        in_valid_i <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk_i);
      end
      q = random_query();
      send_query(q);
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
